### rtl/core/rrd_pkg.sv
package rrd_pkg;

  localparam int unsigned RingBytesDef     = 65536;
  localparam int unsigned MaxFrameBytesDef = 2048;

  localparam int unsigned PosW      = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FrameCntW = 14;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_TAIL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAD = 2'd1;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [ByteW-1:0]     data;
    logic                 last;
    logic [FrameCntW-1:0] frames;
    logic [PosW-1:0]      pos;
  } result_t;

  // up to two results per request: a payload byte, then done
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### rtl/core/rrd_ifs.sv
interface rrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring_byte;

  modport source (output valid, output ring_byte, input ready);
  modport sink   (input valid, input ring_byte, output ready);
endinterface

interface rrd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic [13:0] frames_done;
  logic [31:0] consumed_position;

  modport source (output valid, output result_kind, output frame_byte, output frame_last,
                  output frames_done, output consumed_position, input ready);
  modport sink   (input valid, input result_kind, input frame_byte, input frame_last,
                  input frames_done, input consumed_position, output ready);
endinterface

### rtl/core/rrd_walk.sv
module rrd_walk #(
  parameter int unsigned RING_BYTES      = rrd_pkg::RingBytesDef,
  parameter int unsigned MAX_FRAME_BYTES = rrd_pkg::MaxFrameBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rrd_pkg::PosW-1:0]     cfg_data_i,
  input  logic                         accept_i,
  input  logic [rrd_pkg::ByteW-1:0]    ring_byte_i,
  output rrd_pkg::push_t               push_o
);

  localparam int unsigned LenW      = $clog2(MAX_FRAME_BYTES + 4);
  localparam int unsigned PosW      = rrd_pkg::PosW;
  localparam int unsigned FrameCntW = rrd_pkg::FrameCntW;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_PAD,
    PH_SPANERR,
    PH_STOPPED
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [1:0]                    hdr_cnt_q, hdr_cnt_d;
  logic [PosW-1:0]               len_acc_q, len_acc_d;
  logic [LenW-1:0]               rec_cnt_q, rec_cnt_d;
  logic [PosW-1:0]               rec_start_q, rec_start_d;
  logic [PosW-1:0]               byte_pos_q, byte_pos_d;
  logic [rrd_pkg::FrameCntW-1:0] frame_cnt_q, frame_cnt_d;
  logic [PosW-1:0]               tail_q, tail_d;
  logic [PosW-1:0]               head_q, head_d;

  logic            cfg_hit;
  logic [PosW-1:0] span;
  phase_e          restart_phase;
  logic [PosW-1:0] hdr_len;
  logic [LenW-1:0] hdr_plus3;
  logic [LenW-1:0] hdr_padded;
  logic [PosW-1:0] rec_len;
  logic [PosW-1:0] room;
  logic [LenW-1:0] acc_plus3;
  logic [LenW-1:0] acc_padded;
  logic [LenW-1:0] cnt_inc;
  logic [PosW-1:0] pos_inc;
  logic            at_head;
  rrd_pkg::push_t  push;

  assign cfg_hit = cfg_we_i &&
                   (cfg_index_i == rrd_pkg::CFG_TAIL || cfg_index_i == rrd_pkg::CFG_HEAD);
  assign tail_d  = (cfg_hit && cfg_index_i == rrd_pkg::CFG_TAIL) ? cfg_data_i : tail_q;
  assign head_d  = (cfg_hit && cfg_index_i == rrd_pkg::CFG_HEAD) ? cfg_data_i : head_q;
  assign span    = head_d - tail_d;

  always_comb begin
    if (span == '0) begin
      restart_phase = PH_STOPPED;
    end else if (span > PosW'(RING_BYTES)) begin
      restart_phase = PH_SPANERR;
    end else begin
      restart_phase = PH_HEADER;
    end
  end

  assign hdr_len    = len_acc_q | (PosW'(ring_byte_i) << {hdr_cnt_q, 3'b000});
  assign hdr_plus3  = hdr_len[LenW-1:0] + LenW'(3);
  assign hdr_padded = {hdr_plus3[LenW-1:2], 2'b00};
  assign rec_len    = PosW'(hdr_padded) + PosW'(4);
  assign room       = head_q - rec_start_q;

  assign acc_plus3  = len_acc_q[LenW-1:0] + LenW'(3);
  assign acc_padded = {acc_plus3[LenW-1:2], 2'b00};
  assign cnt_inc    = rec_cnt_q + LenW'(1);
  assign pos_inc    = byte_pos_q + PosW'(1);
  assign at_head    = pos_inc == head_q;

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    len_acc_d   = len_acc_q;
    rec_cnt_d   = rec_cnt_q;
    rec_start_d = rec_start_q;
    byte_pos_d  = byte_pos_q;
    frame_cnt_d = frame_cnt_q;
    push        = '0;

    if (cfg_hit) begin
      phase_d     = restart_phase;
      hdr_cnt_d   = '0;
      len_acc_d   = '0;
      rec_cnt_d   = '0;
      rec_start_d = tail_d;
      byte_pos_d  = tail_d;
      frame_cnt_d = '0;
    end else if (accept_i) begin
      unique case (phase_q)
        PH_SPANERR: begin
          phase_d          = PH_STOPPED;
          push.count       = 2'd1;
          push.first.kind  = rrd_pkg::KIND_ERROR;
        end
        PH_HEADER: begin
          len_acc_d  = hdr_len;
          hdr_cnt_d  = hdr_cnt_q + 2'd1;
          byte_pos_d = pos_inc;
          if (hdr_cnt_q == 2'd3) begin
            if (hdr_len == '0 || hdr_len > PosW'(MAX_FRAME_BYTES) || rec_len > room) begin
              phase_d         = PH_STOPPED;
              push.count      = 2'd1;
              push.first.kind = rrd_pkg::KIND_ERROR;
            end else begin
              rec_cnt_d = '0;
              phase_d   = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD, PH_PAD: begin
          byte_pos_d = pos_inc;
          rec_cnt_d  = cnt_inc;
          if (phase_q == PH_PAYLOAD) begin
            push.count      = 2'd1;
            push.first.kind = rrd_pkg::KIND_BYTE;
            push.first.data = ring_byte_i;
            push.first.last = cnt_inc >= len_acc_q[LenW-1:0];
            if (cnt_inc >= len_acc_q[LenW-1:0]) begin
              phase_d = PH_PAD;
            end
          end
          if (cnt_inc >= acc_padded) begin
            frame_cnt_d = frame_cnt_q + FrameCntW'(1);
            rec_start_d = pos_inc;
            hdr_cnt_d   = '0;
            len_acc_d   = '0;
            rec_cnt_d   = '0;
            phase_d     = at_head ? PH_STOPPED : PH_HEADER;
            if (at_head) begin
              if (phase_q == PH_PAYLOAD) begin
                push.count       = 2'd2;
                push.second.kind = rrd_pkg::KIND_DONE;
              end else begin
                push.count      = 2'd1;
                push.first.kind = rrd_pkg::KIND_DONE;
              end
            end
          end
        end
        PH_STOPPED: begin
        end
        default: begin
        end
      endcase
    end

    push.first.frames  = frame_cnt_d;
    push.first.pos     = rec_start_d;
    push.second.frames = frame_cnt_d;
    push.second.pos    = rec_start_d;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STOPPED;
      hdr_cnt_q   <= '0;
      len_acc_q   <= '0;
      rec_cnt_q   <= '0;
      rec_start_q <= '0;
      byte_pos_q  <= '0;
      frame_cnt_q <= '0;
      tail_q      <= '0;
      head_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      len_acc_q   <= len_acc_d;
      rec_cnt_q   <= rec_cnt_d;
      rec_start_q <= rec_start_d;
      byte_pos_q  <= byte_pos_d;
      frame_cnt_q <= frame_cnt_d;
      tail_q      <= tail_d;
      head_q      <= head_d;
    end
  end

  a_pair_is_byte_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> push_o.first.kind == rrd_pkg::KIND_BYTE && push_o.first.last
                             && push_o.second.kind == rrd_pkg::KIND_DONE)
    else $error("two-result request is not last byte followed by done");

  a_stop_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2 || (push_o.count == 2'd1 &&
     (push_o.first.kind == rrd_pkg::KIND_DONE || push_o.first.kind == rrd_pkg::KIND_ERROR)))
    |=> push_o.count == 2'd0)
    else $error("result produced after walk ended");

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count != 2'd0 |-> accept_i && !cfg_hit)
    else $error("result pushed without an accepted byte");

endmodule

### rtl/core/rrd_outq.sv
module rrd_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrd_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output rrd_pkg::result_t data_o
);

  localparam int unsigned Depth = 3;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rrd_pkg::result_t q_q [Depth];
  rrd_pkg::result_t q_d [Depth];
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;
  logic [CntW-1:0]  base;

  assign valid_o = count_q != '0;
  assign data_o  = q_q[0];
  assign room_o  = count_q <= CntW'(1);
  assign pop     = valid_o && ready_i;
  assign base    = count_q - CntW'(pop);
  assign count_d = base + CntW'(push_i.count);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      q_d[i] = q_q[i];
    end
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        q_d[i] = q_q[i + 1];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (push_i.count != 2'd0 && base == CntW'(i)) begin
        q_d[i] = push_i.first;
      end
      if (push_i.count == 2'd2 && base + CntW'(1) == CntW'(i)) begin
        q_d[i] = push_i.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> count_q <= CntW'(1))
    else $error("result queue overflow");

  a_push_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd3)
    else $error("illegal push count");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> count_q == $past(count_q) - CntW'(1))
    else $error("queue count lost an entry");

endmodule

### rtl/core/ring_record_deframer.sv
// Ring record deframer.
// byte_i carries ring bytes in stream order starting at tail_position; the
// feeder handles address wrap. Each record is a little-endian 32-bit length,
// the payload, then padding to a 4-byte boundary. result_o returns one item
// per payload byte (kind 0, frame_last on the final byte), then one done
// item when the walk reaches head_position, or one error item on a bad
// length, a record that overruns the head, or a span larger than the ring.
// Padding and header bytes give no byte item; after done or error the walk is
// stopped and bytes are taken and dropped.
// Writing tail_position (index 0) or head_position (index 1) on the cfg port
// restarts the walk; the user must write only while the block is idle (the
// block itself does not enforce it). Timing: a byte is taken every cycle while the
// receiver keeps up, except that byte_i.ready drops after a last payload byte
// that also ends the walk (two results). Each result goes into a 3-entry
// result queue before result_o; byte_i.ready drops while it holds two or
// more results, so a stalled receiver backs up into the byte channel
// without losing anything.
// Reset clears both positions to zero, an empty span: the walk is stopped
// until the registers are written.
module ring_record_deframer #(
  parameter int unsigned RING_BYTES      = rrd_pkg::RingBytesDef,
  parameter int unsigned MAX_FRAME_BYTES = rrd_pkg::MaxFrameBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rrd_pkg::PosW-1:0]     cfg_data_i,
  rrd_byte_if.sink                     byte_i,
  rrd_result_if.source                 result_o
);

  logic             room;
  logic             accept;
  rrd_pkg::push_t   push;
  rrd_pkg::result_t head;

  assign byte_i.ready = room;
  assign accept       = byte_i.valid && room;

  rrd_walk #(
    .RING_BYTES      (RING_BYTES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .ring_byte_i (byte_i.ring_byte),
    .push_o      (push)
  );

  rrd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (head)
  );

  assign result_o.result_kind       = head.kind;
  assign result_o.frame_byte        = head.data;
  assign result_o.frame_last        = head.last;
  assign result_o.frames_done       = head.frames;
  assign result_o.consumed_position = head.pos;

endmodule

### tb/ring_record_deframer_tb.sv
`timescale 1ns / 100ps

module ring_record_deframer_tb;
  import rrd_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    WALK_HEADER,
    WALK_PAYLOAD,
    WALK_PAD,
    WALK_SPAN_ERROR,
    WALK_STOPPED
  } walk_phase_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PosW-1:0]    cfg_data_i;

  rrd_byte_if   byte_ch ();
  rrd_result_if result_ch ();

  ring_record_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .byte_i      (byte_ch),
    .result_o    (result_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // walk state mirrored from the deframing rules
  walk_phase_e          walk_phase;
  logic [1:0]           hdr_seen;
  logic [31:0]          frame_len;
  logic [31:0]          rec_count;
  logic [31:0]          rec_start;
  logic [31:0]          walk_pos;
  logic [31:0]          walk_tail;
  logic [31:0]          walk_head;
  logic [FrameCntW-1:0] frames_closed;

  result_t     pending_results[$];
  result_t     due_result;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned walk_bytes;
  int unsigned items_sent;
  int unsigned walks_run;
  int unsigned receiver_hold_cycles;
  bit          sender_gaps;
  bit          receiver_stalls;

  function automatic void restart_walk();
    logic [31:0] span;
    span          = walk_head - walk_tail;
    hdr_seen      = '0;
    frame_len     = '0;
    rec_count     = '0;
    rec_start     = walk_tail;
    walk_pos      = walk_tail;
    frames_closed = '0;
    if (span == 0) walk_phase = WALK_STOPPED;
    else if (span > RingBytesDef) walk_phase = WALK_SPAN_ERROR;
    else walk_phase = WALK_HEADER;
  endfunction

  function automatic void push_expect(input kind_e kind, input logic [7:0] data,
                                      input logic last);
    result_t r;
    r.kind   = kind;
    r.data   = data;
    r.last   = last;
    r.frames = frames_closed;
    r.pos    = rec_start;
    pending_results.push_back(r);
  endfunction

  function automatic bit close_record();
    frames_closed = frames_closed + FrameCntW'(1);
    rec_start     = walk_pos;
    hdr_seen      = '0;
    frame_len     = '0;
    rec_count     = '0;
    if (walk_pos == walk_head) begin
      walk_phase = WALK_STOPPED;
      return 1'b1;
    end
    walk_phase = WALK_HEADER;
    return 1'b0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [31:0] padded;
    logic [32:0] rec_len;
    bit          reached;
    padded = (frame_len + 32'd3) & ~32'd3;
    case (walk_phase)
      WALK_SPAN_ERROR: begin
        walk_phase = WALK_STOPPED;
        push_expect(KIND_ERROR, 8'd0, 1'b0);
      end
      WALK_HEADER: begin
        frame_len = frame_len | (32'(b) << (8 * hdr_seen));
        hdr_seen  = hdr_seen + 2'd1;
        walk_pos  = walk_pos + 32'd1;
        if (hdr_seen == 2'd0) begin
          rec_len = 33'd4 + {1'b0, (frame_len + 32'd3) & ~32'd3};
          if (frame_len == 0 || frame_len > MaxFrameBytesDef) begin
            walk_phase = WALK_STOPPED;
            push_expect(KIND_ERROR, 8'd0, 1'b0);
          end else if (rec_len > {1'b0, walk_head - rec_start}) begin
            walk_phase = WALK_STOPPED;
            push_expect(KIND_ERROR, 8'd0, 1'b0);
          end else begin
            rec_count  = '0;
            walk_phase = WALK_PAYLOAD;
          end
        end
      end
      WALK_PAYLOAD: begin
        walk_pos  = walk_pos + 32'd1;
        rec_count = rec_count + 32'd1;
        if (rec_count >= frame_len) begin
          reached = 1'b0;
          if (rec_count >= padded) reached = close_record();
          else walk_phase = WALK_PAD;
          push_expect(KIND_BYTE, b, 1'b1);
          if (reached) push_expect(KIND_DONE, 8'd0, 1'b0);
        end else begin
          push_expect(KIND_BYTE, b, 1'b0);
        end
      end
      WALK_PAD: begin
        walk_pos  = walk_pos + 32'd1;
        rec_count = rec_count + 32'd1;
        if (rec_count >= padded && close_record()) push_expect(KIND_DONE, 8'd0, 1'b0);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $realtime);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", result_ch.result_kind, 32'd0);
      end else begin
        due_result = pending_results.pop_front();
        results_seen++;
        if (result_ch.result_kind !== due_result.kind)
          report_mismatch("result_kind", result_ch.result_kind, due_result.kind);
        if (result_ch.frame_byte !== due_result.data)
          report_mismatch("frame_byte", result_ch.frame_byte, due_result.data);
        if (result_ch.frame_last !== due_result.last)
          report_mismatch("frame_last", result_ch.frame_last, due_result.last);
        if (result_ch.frames_done !== due_result.frames)
          report_mismatch("frames_done", result_ch.frames_done, due_result.frames);
        if (result_ch.consumed_position !== due_result.pos)
          report_mismatch("consumed_position", result_ch.consumed_position, due_result.pos);
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (receiver_hold_cycles != 0) begin
        result_ch.ready <= 1'b0;
        repeat (receiver_hold_cycles) @(negedge clk_i);
        receiver_hold_cycles = 0;
        result_ch.ready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.ring_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    items_sent++;
    if (walk_phase != WALK_STOPPED) walk_bytes++;
    deframe_byte(b);
  endtask

  task automatic send_noise(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) send_byte($urandom_range(0, 255));
  endtask

  // header, then payload and padding only when the length is a sane one
  task automatic send_record(input logic [31:0] len_field);
    int unsigned k;
    int unsigned body;
    body = 0;
    for (k = 0; k < 4; k++) send_byte(len_field[8*k +: 8]);
    if (len_field != 0 && len_field <= MaxFrameBytesDef) body = (len_field + 3) & ~32'd3;
    send_noise(body);
  endtask

  task automatic settle();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_TAIL) begin
      walk_tail = value;
      restart_walk();
    end else if (idx == CFG_HEAD) begin
      walk_head = value;
      restart_walk();
    end
  endtask

  task automatic start_walk(input logic [31:0] tail, input logic [31:0] head);
    write_reg(CFG_TAIL, tail);
    write_reg(CFG_HEAD, head);
    walks_run++;
  endtask

  function automatic logic [31:0] record_span(input logic [31:0] len);
    return 32'd4 + ((len + 32'd3) & ~32'd3);
  endfunction

  task automatic test_empty_span();
    send_noise(4);
    start_walk(32'd5, 32'd5);
    send_record(32'd4);
  endtask

  task automatic test_record_shapes();
    // padding of three, two, one, then a done raised by padding
    start_walk(32'd0, 32'd36);
    send_record(32'd1);
    send_record(32'd2);
    send_record(32'd3);
    send_record(32'd5);
    send_noise(2);
    // last payload byte meets the head: byte then done in one request
    start_walk(32'd100, 32'd108);
    send_record(32'd4);
    send_noise(2);
  endtask

  task automatic test_bad_lengths();
    start_walk(32'd0, 32'd64);
    send_record(32'd0);
    send_noise(3);
    start_walk(32'd0, 32'd4096);
    send_record(MaxFrameBytesDef + 1);
    start_walk(32'd0, 32'd64);
    send_record(32'hFFFF_FFFF);
    // record longer than the span
    start_walk(32'd0, 32'd8);
    send_record(32'd8);
    // two bytes left over after the last record, too short for one
    start_walk(32'd0, 32'd10);
    send_record(32'd4);
    send_noise(4);
  endtask

  task automatic test_span_limits();
    start_walk(32'd0, RingBytesDef + 1);
    send_noise(3);
    start_walk(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_noise(2);
    // largest legal span; walk left open and restarted by the next write
    start_walk(32'd0, RingBytesDef);
    send_record(32'd8);
    send_record(32'd13);
    start_walk(32'hFFFF_FFF7, 32'hFFFF_FFFF);
    send_record(32'd3);
  endtask

  task automatic test_position_wrap();
    start_walk(32'hFFFF_FFF6, 32'hFFFF_FFF6 + 32'd28);
    send_record(32'd3);
    send_record(32'd7);
    send_record(32'd1);
    start_walk(32'hFFFF_FFF8, 32'd0);
    send_record(32'd4);
  endtask

  task automatic test_spare_index();
    start_walk(32'd0, 32'd40);
    send_record(32'd6);
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
    send_record(32'd20);
  endtask

  // maximum length is taken; only the start of the payload is sent
  task automatic test_max_frame();
    logic [31:0] tail;
    logic [31:0] len;
    int unsigned k;
    tail = $urandom;
    len  = MaxFrameBytesDef;
    start_walk(tail, tail + record_span(len));
    for (k = 0; k < 4; k++) send_byte(len[8*k +: 8]);
    send_noise(64);
  endtask

  task automatic test_backpressure();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    start_walk(32'd64, 32'd64 + record_span(32'd64) + record_span(32'd9));
    receiver_hold_cycles = 300;
    send_record(32'd64);
    send_record(32'd9);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  task automatic test_random_walks();
    logic [31:0] lens [8];
    logic [31:0] tail;
    logic [31:0] head;
    logic [31:0] total;
    int unsigned nrec;
    int unsigned mode;
    int unsigned i;
    bit          late;
    while (items_sent < 1650) begin
      late            = items_sent > 1350;
      sender_gaps     = !late && $urandom_range(0, 3) != 0;
      receiver_stalls = !late && $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 3))
        0:       tail = $urandom_range(0, 64);
        1:       tail = 32'hFFFF_FFFF - $urandom_range(0, 40);
        default: tail = $urandom;
      endcase
      nrec  = $urandom_range(1, 6);
      total = '0;
      for (i = 0; i < nrec; i++) begin
        if ($urandom_range(0, 99) == 0) lens[i] = $urandom_range(256, MaxFrameBytesDef);
        else lens[i] = $urandom_range(1, 16);
        total = total + record_span(lens[i]);
      end
      mode = $urandom_range(0, 19);
      head = tail + total;
      case (mode)
        16: begin
          i = $urandom_range(0, nrec - 1);
          case ($urandom_range(0, 2))
            0:       lens[i] = 32'd0;
            1:       lens[i] = $urandom_range(MaxFrameBytesDef + 1, MaxFrameBytesDef + 64);
            default: lens[i] = $urandom | 32'h0000_1000;
          endcase
        end
        17:      head = tail + total - $urandom_range(1, 3);
        18:      head = tail + total + $urandom_range(1, 12);
        19:      head = tail + RingBytesDef + 1 + $urandom_range(0, 1 << 20);
        default: ;
      endcase
      start_walk(tail, head);
      for (i = 0; i < nrec; i++) send_record(lens[i]);
      send_noise(mode == 18 ? $urandom_range(4, 8) : $urandom_range(0, 3));
    end
  endtask

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_index_i          <= CFG_TAIL;
    cfg_data_i           <= '0;
    byte_ch.valid        <= 1'b0;
    byte_ch.ring_byte    <= '0;
    receiver_hold_cycles = 0;
    items_sent           = 0;
    sender_gaps          = 1'b1;
    receiver_stalls      = 1'b1;
    walk_tail            = '0;
    walk_head            = '0;
    restart_walk();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_span();
    test_record_shapes();
    test_bad_lengths();
    test_span_limits();
    test_position_wrap();
    test_spare_index();
    test_max_frame();
    test_backpressure();
    test_random_walks();

    settle();
    repeat (8) @(posedge clk_i);
    $display("Walked %0d ring spans, %0d bytes sent, %0d deframed, %0d results compared.",
             walks_run, items_sent, walk_bytes, results_seen);
    $display("Covered padding shapes, bad lengths, span limits, position wrap, backpressure.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
